// ----- hdl/bmhq_pkg.sv -----
// Shared types and codes for the binary min-heap priority queue.
// Stands alone; the queue core imports it.
package bmhq_pkg;

   localparam int KEY_W     = 32;
   localparam int TAG_W     = 32;
   localparam int STATUS_W  = 2;
   localparam int ENTRIES_W = 11;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic                out_valid;
      logic [KEY_W-1:0]    out_key;
      logic [TAG_W-1:0]    out_tag;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// ----- hdl/binary_min_heap_queue_core.sv -----
// Priority queue kept as a binary min-heap of (key, tag) entries in one
// synchronous memory with a registered read port. An insert into an empty heap
// places its entry without a walk; otherwise the moved entry travels at most
// log2(CAPACITY) levels. The walk is set by the single memory port pair: sift-up
// reads one parent per cycle while writing the displaced one back, sift-down reads
// the left and then the right child before each compare-and-move. One request is
// in flight at a time; a new request is taken while the previous result still
// waits on rsp. Every request yields one result with the entry count after it; an
// insert into a full heap or a remove from an empty heap is reported and changes
// nothing.
module binary_min_heap_queue_core #(
   parameter int CAPACITY = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [bmhq_pkg::KEY_W-1:0]         req_key,
   input  logic [bmhq_pkg::TAG_W-1:0]         req_tag,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_out_valid,
   output logic [bmhq_pkg::KEY_W-1:0]         rsp_out_key,
   output logic [bmhq_pkg::TAG_W-1:0]         rsp_out_tag,
   output logic [bmhq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bmhq_pkg::ENTRIES_W-1:0]     rsp_entries
);
   import bmhq_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LW    = IDX_W + 2;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_UP      = 7'b0000010,
      S_DN_ROOT = 7'b0000100,
      S_DN_TAIL = 7'b0001000,
      S_DN_L    = 7'b0010000,
      S_DN_R    = 7'b0100000,
      S_FIN     = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   par_ff, par_in;
   entry_type          ent_ff, ent_in;
   entry_type          lft_ff, lft_in;
   logic               has_r_ff, has_r_in;
   logic               fin_we_ff, fin_we_in;
   result_type         res_ff, res_in;

   logic               rsp_valid_ff;
   result_type         rsp_res_ff;
   logic [ENTRIES_W-1:0] rsp_entries_ff;
   logic               rsp_load;

   // heap storage
   entry_type          mem [CAPACITY];
   entry_type          rd_data_ff;
   logic               mem_we, mem_re;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   entry_type          mem_wdata;

   // index arithmetic
   logic [IDX_W-1:0]   up_src, up_dec, up_par;
   logic [LW-1:0]      pos_left, pos_right;
   logic               use_r;
   entry_type          child;
   logic [IDX_W-1:0]   cidx;
   logic [IDX_W-1:0]   desc_idx;
   logic [LW-1:0]      desc_left, desc_right;
   logic               desc_go, desc_has_r;
   logic               req_accept;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);

   assign up_src = (state_ff == S_IDLE) ? count_ff[IDX_W-1:0] : par_ff;
   assign up_dec = up_src - IDX_W'(1);
   assign up_par = up_dec >> 1;

   assign pos_left  = {1'b0, pos_ff, 1'b1};
   assign pos_right = {1'b0, pos_ff, 1'b0} + LW'(2);

   assign use_r = has_r_ff && (rd_data_ff.key < lft_ff.key);
   assign child = use_r ? rd_data_ff : lft_ff;
   assign cidx  = use_r ? pos_right[IDX_W-1:0] : pos_left[IDX_W-1:0];

   assign desc_idx   = (state_ff == S_DN_TAIL) ? '0 : cidx;
   assign desc_left  = {1'b0, desc_idx, 1'b1};
   assign desc_right = {1'b0, desc_idx, 1'b0} + LW'(2);
   assign desc_go    = desc_left < LW'(count_ff);
   assign desc_has_r = desc_right < LW'(count_ff);

   assign rsp_load = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      par_in    = par_ff;
      ent_in    = ent_ff;
      lft_in    = lft_ff;
      has_r_in  = has_r_ff;
      fin_we_in = fin_we_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = ent_ff;
      mem_re    = 1'b0;
      mem_raddr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_in = '0;
               if (req_type == REQ_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     res_in.status = STATUS_FULL;
                     fin_we_in     = 1'b0;
                     state_in      = S_FIN;
                  end else begin
                     ent_in    = '{key: req_key, tag: req_tag};
                     pos_in    = count_ff[IDX_W-1:0];
                     count_in  = count_ff + CNT_W'(1);
                     fin_we_in = 1'b1;
                     if (count_ff == '0) begin
                        state_in = S_FIN;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = up_par;
                        par_in    = up_par;
                        state_in  = S_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status = STATUS_EMPTY;
                     fin_we_in     = 1'b0;
                     state_in      = S_FIN;
                  end else begin
                     res_in.out_valid = 1'b1;
                     count_in         = count_ff - CNT_W'(1);
                     mem_re           = 1'b1;
                     mem_raddr        = '0;
                     state_in         = S_DN_ROOT;
                  end
               end
            end
         end
         S_UP: begin
            if (ent_ff.key < rd_data_ff.key) begin
               // move the parent down into the hole, climb one level
               mem_we    = 1'b1;
               mem_waddr = pos_ff;
               mem_wdata = rd_data_ff;
               pos_in    = par_ff;
               if (par_ff == '0) begin
                  state_in = S_FIN;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = up_par;
                  par_in    = up_par;
               end
            end else begin
               state_in = S_FIN;
            end
         end
         S_DN_ROOT: begin
            res_in.out_key = rd_data_ff.key;
            res_in.out_tag = rd_data_ff.tag;
            mem_re         = 1'b1;
            mem_raddr      = count_ff[IDX_W-1:0];
            state_in       = S_DN_TAIL;
         end
         S_DN_TAIL: begin
            ent_in    = rd_data_ff;
            pos_in    = '0;
            fin_we_in = 1'b1;
            if (desc_go) begin
               mem_re    = 1'b1;
               mem_raddr = desc_left[IDX_W-1:0];
               has_r_in  = desc_has_r;
               state_in  = S_DN_L;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DN_L: begin
            lft_in = rd_data_ff;
            if (has_r_ff) begin
               mem_re    = 1'b1;
               mem_raddr = pos_right[IDX_W-1:0];
            end
            state_in = S_DN_R;
         end
         S_DN_R: begin
            if (ent_ff.key < child.key) begin
               state_in = S_FIN;
            end else begin
               // ties swap: lift the child into the hole, descend
               mem_we    = 1'b1;
               mem_waddr = pos_ff;
               mem_wdata = child;
               pos_in    = cidx;
               if (desc_go) begin
                  mem_re    = 1'b1;
                  mem_raddr = desc_left[IDX_W-1:0];
                  has_r_in  = desc_has_r;
                  state_in  = S_DN_L;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            // place the moving entry; rewriting the same data while held is harmless
            mem_we    = fin_we_ff;
            mem_waddr = pos_ff;
            mem_wdata = ent_ff;
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      par_ff    <= par_in;
      ent_ff    <= ent_in;
      lft_ff    <= lft_in;
      has_r_ff  <= has_r_in;
      fin_we_ff <= fin_we_in;
      res_ff    <= res_in;
      if (rsp_load) begin
         rsp_res_ff     <= res_ff;
         rsp_entries_ff <= ENTRIES_W'(count_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_valid = rsp_res_ff.out_valid;
   assign rsp_out_key   = rsp_res_ff.out_key;
   assign rsp_out_tag   = rsp_res_ff.out_tag;
   assign rsp_status    = rsp_res_ff.status;
   assign rsp_entries   = rsp_entries_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re && (mem_waddr == mem_raddr)))
      else $error("read and write hit the same heap slot");

   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == STATUS_OK)
      else $error("returned entry with a refusal status");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_type == REQ_INSERT) && (count_ff != CNT_W'(CAPACITY))
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance the entry count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != S_IDLE)
      else $error("transaction accepted but sequencer stayed idle");
`endif

endmodule

// ----- tb/sv/bmhq_result_checker.sv -----
// Result checker for the binary min-heap queue core: watches both channels,
// keeps its own heap image and compares every result with what it predicts.
// Depends on bmhq_pkg for widths, request kinds and status codes.
module bmhq_result_checker #(
   parameter int CAPACITY = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_type,
   input  logic [bmhq_pkg::KEY_W-1:0]     req_key,
   input  logic [bmhq_pkg::TAG_W-1:0]     req_tag,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_out_valid,
   input  logic [bmhq_pkg::KEY_W-1:0]     rsp_out_key,
   input  logic [bmhq_pkg::TAG_W-1:0]     rsp_out_tag,
   input  logic [bmhq_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [bmhq_pkg::ENTRIES_W-1:0] rsp_entries,
   output int                             mismatches,
   output int                             pending,
   output int                             results_seen,
   output int                             full_refusals,
   output int                             empty_refusals,
   output int                             peak_entries
);
   timeunit 1ns;
   timeprecision 1ps;

   import bmhq_pkg::*;

   typedef struct packed {
      result_type             r;
      logic [ENTRIES_W-1:0]   entries;
   } heap_outcome_type;

   entry_type        heap_slots [CAPACITY];
   int unsigned      held;
   heap_outcome_type outcomes_due [$];

   // Apply one request to the heap image and queue the outcome it must produce.
   function automatic void heap_apply(logic kind, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
      heap_outcome_type res;
      entry_type        tmp;
      int unsigned      c, p, s, r, n;
      res = '0;
      if (kind == REQ_INSERT) begin
         if (held >= CAPACITY) begin
            res.r.status = STATUS_FULL;
         end else begin
            c = held;
            heap_slots[c] = {k, t};
            while (c > 0) begin
               p = (c - 1) / 2;
               if (!(heap_slots[c].key < heap_slots[p].key)) break;
               tmp = heap_slots[c];
               heap_slots[c] = heap_slots[p];
               heap_slots[p] = tmp;
               c = p;
            end
            held++;
            res.r.status = STATUS_OK;
         end
      end else begin
         if (held == 0) begin
            res.r.status = STATUS_EMPTY;
         end else begin
            res.r.out_valid = 1'b1;
            res.r.out_key   = heap_slots[0].key;
            res.r.out_tag   = heap_slots[0].tag;
            res.r.status    = STATUS_OK;
            n = held - 1;
            heap_slots[0] = heap_slots[n];
            held = n;
            p = 0;
            // ties still move down: stop only on a strictly smaller parent
            while (2 * p + 1 < n) begin
               s = 2 * p + 1;
               r = 2 * p + 2;
               if (r < n && heap_slots[r].key < heap_slots[s].key) s = r;
               if (heap_slots[p].key < heap_slots[s].key) break;
               tmp = heap_slots[p];
               heap_slots[p] = heap_slots[s];
               heap_slots[s] = tmp;
               p = s;
            end
         end
      end
      res.entries = held[ENTRIES_W-1:0];
      outcomes_due.push_back(res);
   endfunction

   always @(posedge clock) begin
      heap_outcome_type want;
      if (reset) begin
         held = 0;
         outcomes_due.delete();
         mismatches     <= 0;
         results_seen   <= 0;
         full_refusals  <= 0;
         empty_refusals <= 0;
         peak_entries   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            heap_apply(req_type, req_key, req_tag);
            if (held > peak_entries) peak_entries <= held;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (rsp_status == STATUS_FULL) full_refusals <= full_refusals + 1;
            if (rsp_status == STATUS_EMPTY) empty_refusals <= empty_refusals + 1;
            if (outcomes_due.size() == 0) begin
               if (mismatches < 10)
                  $display({"%0t: result with nothing outstanding: ",
                            "valid=%0b key=%h tag=%h status=%0d entries=%0d"},
                           $realtime, rsp_out_valid, rsp_out_key, rsp_out_tag, rsp_status,
                           rsp_entries);
               mismatches <= mismatches + 1;
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_out_valid !== want.r.out_valid || rsp_out_key !== want.r.out_key ||
                   rsp_out_tag !== want.r.out_tag || rsp_status !== want.r.status ||
                   rsp_entries !== want.entries) begin
                  if (mismatches < 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected valid=%0b key=%h tag=%h status=%0d entries=%0d",
                              want.r.out_valid, want.r.out_key, want.r.out_tag,
                              want.r.status, want.entries);
                     $display("   actual   valid=%0b key=%h tag=%h status=%0d entries=%0d",
                              rsp_out_valid, rsp_out_key, rsp_out_tag, rsp_status,
                              rsp_entries);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
      pending <= outcomes_due.size();
   end

endmodule

// ----- tb/sv/tb_binary_min_heap_queue_core.sv -----
// Top of the heap queue testbench: clock, reset, request and stall stimulus.
// Depends on bmhq_pkg, binary_min_heap_queue_core and bmhq_result_checker.
module tb_binary_min_heap_queue_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bmhq_pkg::*;

   localparam int CAPACITY      = 1024;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int MIXED_ITEMS   = 300;
   localparam int NEAR_FULL_MIN = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 64;
   localparam int CYCLE_LIMIT   = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_type = REQ_INSERT;
   logic [KEY_W-1:0]      req_key = '0;
   logic [TAG_W-1:0]      req_tag = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_out_valid;
   logic [KEY_W-1:0]      rsp_out_key;
   logic [TAG_W-1:0]      rsp_out_tag;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ENTRIES_W-1:0]  rsp_entries;

   logic gaps_on  = 1'b1;
   logic rsp_hold = 1'b0;
   int   sent_count = 0;
   int   occupancy  = 0;
   int   cycle_count = 0;

   int mismatches, pending, results_seen, full_refusals, empty_refusals, peak_entries;

   binary_min_heap_queue_core #(.CAPACITY(CAPACITY)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_key(req_key), .req_tag(req_tag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_valid(rsp_out_valid),
      .rsp_out_key(rsp_out_key), .rsp_out_tag(rsp_out_tag), .rsp_status(rsp_status),
      .rsp_entries(rsp_entries)
   );

   bmhq_result_checker #(.CAPACITY(CAPACITY)) result_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_key(req_key), .req_tag(req_tag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_valid(rsp_out_valid),
      .rsp_out_key(rsp_out_key), .rsp_out_tag(rsp_out_tag), .rsp_status(rsp_status),
      .rsp_entries(rsp_entries),
      .mismatches(mismatches), .pending(pending), .results_seen(results_seen),
      .full_refusals(full_refusals), .empty_refusals(empty_refusals),
      .peak_entries(peak_entries)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (rsp_hold) rsp_stall <= 1'b1;
      else if (gaps_on) rsp_stall <= ($urandom_range(99) < 10);
      else rsp_stall <= 1'b0;
   end

   // Back-pressure: hold the result side long enough that the request side stalls.
   initial begin
      wait (sent_count >= 500);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Mostly a mix of wide keys, tight keys that force ties, and the extremes.
   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom();
         4, 5, 6:    return $urandom_range(15);
         7:          return '0;
         8:          return '1;
         default:    return {2'($urandom_range(3)), 30'h0};
      endcase
   endfunction

   task automatic send_request(logic kind, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
      while (gaps_on && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_key   <= k;
      req_tag   <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      if (kind == REQ_INSERT && occupancy < CAPACITY) occupancy++;
      if (kind == REQ_REMOVE && occupancy > 0) occupancy--;
   endtask

   initial begin
      int  n;
      int  near_full;
      int  insert_pct;
      bit  reached_full;
      logic kind;

      @(posedge clock);
      while (reset) @(posedge clock);

      // directed: empty refusal, extreme keys and tags, ties, full drain
      send_request(REQ_REMOVE, $urandom(), $urandom());
      send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
      send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
      send_request(REQ_INSERT, 32'd5, 32'd1);
      send_request(REQ_INSERT, 32'd5, 32'd2);
      send_request(REQ_INSERT, 32'd5, 32'd3);
      send_request(REQ_INSERT, 32'd0, 32'h1234_5678);
      repeat (9) send_request(REQ_REMOVE, $urandom(), $urandom());
      send_request(REQ_INSERT, 32'd3, 32'd30);
      send_request(REQ_INSERT, 32'd2, 32'd20);
      send_request(REQ_INSERT, 32'd1, 32'd10);
      repeat (3) send_request(REQ_REMOVE, '1, '1);

      // random: balanced mix near empty, then an insert-heavy climb to full,
      // then a balanced mix around full
      n = 0;
      near_full = 0;
      reached_full = 1'b0;
      while (n < RANDOM_ITEMS || !reached_full || near_full < NEAR_FULL_MIN) begin
         if (n == 100) gaps_on <= 1'b0;
         if (n == 300) gaps_on <= 1'b1;
         if (occupancy >= CAPACITY) reached_full = 1'b1;
         if (n < MIXED_ITEMS) insert_pct = 50;
         else if (!reached_full) insert_pct = 95;
         else insert_pct = 55;
         if (reached_full) near_full++;
         kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
         send_request(kind, pick_key(), $urandom());
         n++;
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests and %0d results, peak occupancy %0d of %0d",
               sent_count, results_seen, peak_entries, CAPACITY);
      $display("Refusals seen: %0d inserts at full, %0d removes at empty; %0d mismatches",
               full_refusals, empty_refusals, mismatches);
      if (mismatches == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
